FILE: hw/rtl/imu_cal_pkg.sv
// ----------------------------------------------------------------------------
// imu_cal_pkg
// Shared constants and types for the IMU calibrate-and-integrate block.
// ----------------------------------------------------------------------------
package imu_cal_pkg;

    // calibration
    localparam int unsigned CAL_SAMPLES_DEF = 10;
    localparam int unsigned CAL_COUNT_W     = 4;
    localparam int unsigned SUM_W           = 21;
    localparam int unsigned OFFSET_W        = 18;
    localparam int unsigned NUM_AXES        = 6;
    localparam int unsigned ACCEL_AXES      = 3;
    localparam int unsigned ONE_G_COUNTS    = 4096;

    // offset divider operand width (biased, always non-negative)
    localparam int unsigned DIV_W           = 26;

    // configuration port
    localparam int unsigned CFG_DATA_W      = 26;
    localparam int unsigned CFG_INDEX_W     = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GYRO_SCALE = 2'd0,
        REG_STILL_LOW  = 2'd1,
        REG_STILL_HIGH = 2'd2,
        REG_GRAVITY    = 2'd3
    } cfg_reg_t;

    localparam logic [15:0] GYRO_SCALE_RST = 16'd1689;
    localparam logic [25:0] STILL_LOW_RST  = 26'd15141437;
    localparam logic [25:0] STILL_HIGH_RST = 26'd18496881;
    localparam logic [11:0] GRAVITY_RST    = 12'd2511;

endpackage

FILE: hw/rtl/imu_cal_div.sv
// ----------------------------------------------------------------------------
// imu_cal_div
// Unsigned divide by a constant through reciprocal multiplication; dividend and quotient are registered.
// ----------------------------------------------------------------------------
module imu_cal_div #(
    parameter int unsigned W = imu_cal_pkg::DIV_W,
    parameter int unsigned D = 20
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    output logic [W-1:0] quotient,
    output logic         done
);

    // floor(x / D) == (x * MULT) >> SHIFT for every x below 2**W
    localparam int unsigned SHIFT = W + $clog2(D);
    localparam logic [W:0]  MULT  =
        (W+1)'(((64'd1 << SHIFT) + 64'(D) - 64'd1) / 64'(D));

    logic [W-1:0] dvd_reg;
    logic [W-1:0] quo_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [2*W:0] prod;

    assign prod = {{(W+1){1'b0}}, dvd_reg} * {{W{1'b0}}, MULT};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            dvd_reg <= dividend;
        if (busy_reg)
            quo_reg <= W'(prod >> SHIFT);
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: hw/rtl/imu_calibrate_and_integrate.sv
// ----------------------------------------------------------------------------
// imu_calibrate_and_integrate
// Gyro/accel bias calibration, scaling and zero-velocity-update integrator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one six-axis sample word per accept (in_valid high, in_stall low).
//   out_* : one result word per accept (out_valid high, out_stall low).
//   cfg_* : register writes, taken on any edge with cfg_we high.
// After reset the first CAL_SAMPLES words are only summed; they are taken at
// one per cycle and give no result. The offset solve that follows runs two
// reciprocal-multiply constant dividers over the six axes, one axis after
// another, with in_stall held high.
// From then on a word is taken every cycle unless every stage is full and
// the receiver stalls. An accepted word passes the input register,
// offset/saturate stage, multiply stage, then magnitude test and velocity
// update into the result register, which also holds the velocity state.
// When the receiver stalls, the result holds and the stages behind it keep
// filling bubbles; in_stall rises only once every stage is occupied.
// Reset restores register defaults, clears velocities and restarts
// calibration.
// ----------------------------------------------------------------------------
module imu_calibrate_and_integrate #(
    parameter int unsigned CAL_SAMPLES = imu_cal_pkg::CAL_SAMPLES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_we,
    input  logic [imu_cal_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imu_cal_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [15:0]                    accel_x_raw,
    input  logic signed [15:0]                    accel_y_raw,
    input  logic signed [15:0]                    accel_z_raw,
    input  logic signed [15:0]                    gyro_x_raw,
    input  logic signed [15:0]                    gyro_y_raw,
    input  logic signed [15:0]                    gyro_z_raw,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [17:0]                    accel_x_g,
    output logic signed [17:0]                    accel_y_g,
    output logic signed [17:0]                    accel_z_g,
    output logic signed [19:0]                    gyro_x_dps,
    output logic signed [19:0]                    gyro_y_dps,
    output logic signed [19:0]                    gyro_z_dps,
    output logic signed [31:0]                    vel_x,
    output logic signed [31:0]                    vel_y,
    output logic signed [31:0]                    vel_z,
    output logic                                  stationary
);

    localparam int unsigned NA  = imu_cal_pkg::NUM_AXES;
    localparam int unsigned NACC = imu_cal_pkg::ACCEL_AXES;
    localparam int unsigned SW  = imu_cal_pkg::SUM_W;
    localparam int unsigned OW  = imu_cal_pkg::OFFSET_W;
    localparam int unsigned CCW = imu_cal_pkg::CAL_COUNT_W;
    localparam int unsigned DW  = imu_cal_pkg::DIV_W;

    localparam int unsigned MEAN_DIV    = 2 * CAL_SAMPLES;
    localparam int unsigned WHOLE_DIV   = CAL_SAMPLES * imu_cal_pkg::ONE_G_COUNTS;
    // biases keep the dividends non-negative; removed from the quotients
    localparam int unsigned MEAN_BIAS   = MEAN_DIV * (2 ** 20) + CAL_SAMPLES;
    localparam int unsigned WHOLE_BIAS  = CAL_SAMPLES * (2 ** 20)
                                          + CAL_SAMPLES * (imu_cal_pkg::ONE_G_COUNTS / 2);

    typedef enum logic [1:0] {
        ST_CAL,
        ST_DIV,
        ST_RUN
    } seq_state_t;

    function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
        logic signed [17:0] r;
        if (v > 19'sd131071)
            r = 18'sd131071;
        else if (v < -19'sd131072)
            r = -18'sd131072;
        else
            r = v[17:0];
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [28:0] v);
        logic signed [19:0] r;
        if (v > 29'sd524287)
            r = 20'sd524287;
        else if (v < -29'sd524288)
            r = -20'sd524288;
        else
            r = v[19:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -33'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [15:0] gyro_scale_reg;
    logic [25:0] still_low_reg;
    logic [25:0] still_high_reg;
    logic [11:0] gravity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_scale_reg <= imu_cal_pkg::GYRO_SCALE_RST;
            still_low_reg  <= imu_cal_pkg::STILL_LOW_RST;
            still_high_reg <= imu_cal_pkg::STILL_HIGH_RST;
            gravity_reg    <= imu_cal_pkg::GRAVITY_RST;
        end
        else if (cfg_we)
        begin
            case (imu_cal_pkg::cfg_reg_t'(cfg_index))
                imu_cal_pkg::REG_GYRO_SCALE: gyro_scale_reg <= cfg_data[15:0];
                imu_cal_pkg::REG_STILL_LOW:  still_low_reg  <= cfg_data[25:0];
                imu_cal_pkg::REG_STILL_HIGH: still_high_reg <= cfg_data[25:0];
                imu_cal_pkg::REG_GRAVITY:    gravity_reg    <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake / pipeline control
    // ------------------------------------------------------------------
    seq_state_t state_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;
    logic in_acc;
    logic run_acc;

    assign rdy3 = !v3_reg || !out_stall;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign in_stall = (state_reg == ST_DIV) || ((state_reg == ST_RUN) && !rdy0);
    assign in_acc   = in_valid && !in_stall;
    assign run_acc  = in_acc && (state_reg == ST_RUN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) v0_reg <= run_acc;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    logic signed [15:0] raw_in [NA];
    assign raw_in[0] = accel_x_raw;
    assign raw_in[1] = accel_y_raw;
    assign raw_in[2] = accel_z_raw;
    assign raw_in[3] = gyro_x_raw;
    assign raw_in[4] = gyro_y_raw;
    assign raw_in[5] = gyro_z_raw;

    // ------------------------------------------------------------------
    // calibration sequencer and offset solve
    // ------------------------------------------------------------------
    logic [CCW-1:0]        cal_count_reg;
    logic signed [SW-1:0]  sums_reg [NA];
    logic signed [OW-1:0]  offsets_reg [NA];
    logic [2:0]            ax_reg;
    logic                  start_reg;

    logic signed [26:0]    sum_ext;
    logic [26:0]           mean_dvd_full;
    logic [26:0]           whole_dvd_full;
    logic [DW-1:0]         mean_quo;
    logic [DW-1:0]         whole_quo;
    logic                  mean_done;
    logic                  whole_done;
    logic                  div_done;
    logic signed [26:0]    mean_val;
    logic signed [26:0]    whole_val;
    logic signed [26:0]    off_full;

    assign sum_ext        = 27'(sums_reg[ax_reg]);
    assign mean_dvd_full  = 27'(sum_ext <<< 1) + 27'(MEAN_BIAS);
    assign whole_dvd_full = 27'(sum_ext) + 27'(WHOLE_BIAS);

    imu_cal_div #(
        .W (DW),
        .D (MEAN_DIV)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (mean_dvd_full[DW-1:0]),
        .quotient (mean_quo),
        .done     (mean_done)
    );

    imu_cal_div #(
        .W (DW),
        .D (WHOLE_DIV)
    ) u_whole_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (whole_dvd_full[DW-1:0]),
        .quotient (whole_quo),
        .done     (whole_done)
    );

    assign div_done  = mean_done && whole_done;
    assign mean_val  = $signed({1'b0, mean_quo}) - 27'sd1048576;
    assign whole_val = $signed({1'b0, whole_quo}) - 27'sd256;

    always_comb
    begin
        if (ax_reg < 3'(NACC))
            off_full = (whole_val <<< 12) - mean_val;
        else
            off_full = -mean_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CAL;
            cal_count_reg <= '0;
            ax_reg        <= '0;
            start_reg     <= 1'b0;
            for (int i = 0; i < NA; i++)
            begin
                sums_reg[i]    <= '0;
                offsets_reg[i] <= '0;
            end
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_CAL:
                begin
                    if (in_acc)
                    begin
                        for (int i = 0; i < NA; i++)
                            sums_reg[i] <= sums_reg[i] + SW'(raw_in[i]);
                        cal_count_reg <= cal_count_reg + CCW'(1);
                        if (cal_count_reg == CCW'(CAL_SAMPLES - 1))
                        begin
                            state_reg <= ST_DIV;
                            ax_reg    <= '0;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        offsets_reg[ax_reg] <= off_full[OW-1:0];
                        if (ax_reg == 3'(NA - 1))
                            state_reg <= ST_RUN;
                        else
                        begin
                            ax_reg    <= ax_reg + 3'd1;
                            start_reg <= 1'b1;
                        end
                    end
                end
                ST_RUN: ;
                default: state_reg <= ST_CAL;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic signed [15:0] raw0_reg [NA];

    always_ff @(posedge clk)
    begin
        if (rdy0 && run_acc)
            for (int i = 0; i < NA; i++)
                raw0_reg[i] <= raw_in[i];
    end

    // ------------------------------------------------------------------
    // stage 1: offset correction, accel saturation
    // ------------------------------------------------------------------
    logic signed [17:0] acc1_reg [NACC];
    logic signed [18:0] gc1_reg  [NACC];
    logic signed [18:0] acc_sum  [NACC];

    always_comb
    begin
        for (int i = 0; i < NACC; i++)
            acc_sum[i] = 19'(raw0_reg[i]) + 19'(offsets_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && v0_reg)
            for (int i = 0; i < NACC; i++)
            begin
                acc1_reg[i] <= sat18(acc_sum[i]);
                gc1_reg[i]  <= 19'(raw0_reg[i+NACC]) + 19'(offsets_reg[i+NACC]);
            end
    end

    // ------------------------------------------------------------------
    // stage 2: products
    // ------------------------------------------------------------------
    logic signed [35:0] sq_c  [NACC];
    logic signed [30:0] av_c  [NACC];
    logic signed [35:0] gp_c  [NACC];
    logic [34:0]        sq2_reg  [NACC];
    logic signed [30:0] av2_reg  [NACC];
    logic signed [35:0] gp2_reg  [NACC];
    logic signed [17:0] acc2_reg [NACC];

    always_comb
    begin
        for (int i = 0; i < NACC; i++)
        begin
            sq_c[i] = acc1_reg[i] * acc1_reg[i];
            av_c[i] = acc1_reg[i] * $signed({1'b0, gravity_reg});
            gp_c[i] = gc1_reg[i] * $signed({1'b0, gyro_scale_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
            for (int i = 0; i < NACC; i++)
            begin
                sq2_reg[i]  <= sq_c[i][34:0];
                av2_reg[i]  <= av_c[i];
                gp2_reg[i]  <= gp_c[i];
                acc2_reg[i] <= acc1_reg[i];
            end
    end

    // ------------------------------------------------------------------
    // stage 3: stillness test, rounding, velocity update, result register
    // ------------------------------------------------------------------
    logic [35:0]        mag;
    logic               still;
    logic signed [36:0] gp_rnd  [NACC];
    logic signed [31:0] av_rnd  [NACC];
    logic signed [32:0] vel_sum [NACC];

    logic signed [17:0] acc3_reg [NACC];
    logic signed [19:0] gyr3_reg [NACC];
    logic signed [31:0] vel_reg  [NACC];
    logic               still_reg;

    assign mag   = 36'(sq2_reg[0]) + 36'(sq2_reg[1]) + 36'(sq2_reg[2]);
    assign still = (mag >= 36'(still_low_reg)) && (mag <= 36'(still_high_reg));

    always_comb
    begin
        for (int i = 0; i < NACC; i++)
        begin
            gp_rnd[i]  = 37'(gp2_reg[i]) + 37'sd128;
            av_rnd[i]  = 32'(av2_reg[i]) + 32'sd128;
            vel_sum[i] = 33'(vel_reg[i]) + 33'($signed(av_rnd[i][31:8]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            for (int i = 0; i < NACC; i++)
            begin
                acc3_reg[i] <= acc2_reg[i];
                gyr3_reg[i] <= sat20($signed(gp_rnd[i][36:8]));
            end
            still_reg <= still;
        end
    end

    // velocity state doubles as the result register's velocity fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NACC; i++)
                vel_reg[i] <= '0;
        end
        else if (rdy3 && v2_reg)
        begin
            for (int i = 0; i < NACC; i++)
                vel_reg[i] <= still ? 32'sd0 : sat32(vel_sum[i]);
        end
    end

    assign out_valid  = v3_reg;
    assign accel_x_g  = acc3_reg[0];
    assign accel_y_g  = acc3_reg[1];
    assign accel_z_g  = acc3_reg[2];
    assign gyro_x_dps = gyr3_reg[0];
    assign gyro_y_dps = gyr3_reg[1];
    assign gyro_z_dps = gyr3_reg[2];
    assign vel_x      = vel_reg[0];
    assign vel_y      = vel_reg[1];
    assign vel_z      = vel_reg[2];
    assign stationary = still_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_result_before_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> (!out_valid && !v0_reg && !v1_reg && !v2_reg))
        else $error("pipeline word present before offsets were solved");

    a_still_zeroes_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stationary) |-> (vel_x == 32'sd0 && vel_y == 32'sd0 && vel_z == 32'sd0))
        else $error("stationary result with nonzero velocity");

    a_solve_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CAL && in_acc && cal_count_reg == CCW'(CAL_SAMPLES - 1))
        |=> (in_stall && start_reg))
        else $error("offset solve did not start after last calibration word");

endmodule
